/* hdl/assert_macros.svh */
// Assertion macros used by the controller of the wear-levelled store.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define AST_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define AST_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

/* hdl/ewls_pkg.sv */
// Shared constants, codes and controller/datapath interface types of the
// wear-levelled byte store. No dependencies.
package ewls_pkg;

  localparam int STORE_BYTES_DEF = 1024;
  localparam int MAX_PART_DEF    = 8;

  localparam int KIND_W = 2;
  localparam int SLOT_W = 3;
  localparam int VAL_W  = 8;
  localparam int ST_W   = 2;
  localparam int CNT_W  = 4;
  localparam int LEN_W  = 10;
  localparam int VER_W  = 8;
  localparam int CFG_IW = 2;
  localparam int CFG_DW = 10;

  localparam logic [KIND_W-1:0] KIND_READ   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_UPDATE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_MOUNT  = 2'd3;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_SLOT  = 2'd1;
  localparam logic [ST_W-1:0] ST_EQUAL = 2'd2;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd3;

  localparam logic [CFG_IW-1:0] CFG_COUNT   = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_LENGTH  = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_VERSION = 2'd2;

  localparam logic [7:0] BYTE_ERASED = 8'hFF;
  localparam logic [7:0] BYTE_ZERO   = 8'h00;

  typedef logic [4:0] op_t;

  localparam op_t OP_NOP      = 5'd0;
  localparam op_t OP_CLR      = 5'd1;
  localparam op_t OP_LOAD     = 5'd2;
  localparam op_t OP_A_CHK    = 5'd3;
  localparam op_t OP_A_RD     = 5'd4;
  localparam op_t OP_A_RVAL   = 5'd5;
  localparam op_t OP_A_CMP    = 5'd6;
  localparam op_t OP_ERASE    = 5'd7;
  localparam op_t OP_A_WR     = 5'd8;
  localparam op_t OP_A_CB_RD  = 5'd9;
  localparam op_t OP_A_CB_WR  = 5'd10;
  localparam op_t OP_M_VER    = 5'd11;
  localparam op_t OP_M_INIT   = 5'd12;
  localparam op_t OP_DIV      = 5'd13;
  localparam op_t OP_M_CC     = 5'd14;
  localparam op_t OP_M_GEOM   = 5'd15;
  localparam op_t OP_PART     = 5'd16;
  localparam op_t OP_BS_INIT  = 5'd17;
  localparam op_t OP_BS_RD    = 5'd18;
  localparam op_t OP_BS_EV    = 5'd19;
  localparam op_t OP_SCAN     = 5'd20;
  localparam op_t OP_SCAN_EV  = 5'd21;
  localparam op_t OP_REC_RD   = 5'd22;
  localparam op_t OP_REC      = 5'd23;

  typedef struct packed {
    op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic mount;
    logic div_done;
    logic no_room;
    logic ver_diff;
    logic erase_last;
    logic lo_gt_hi;
    logic mixed;
    logic scan_go;
    logic part_last;
    logic slot_bad;
    logic rd;
    logic has;
    logic equal;
    logic wrap;
  } dp_stat_t;

endpackage

/* hdl/eeprom_wear_level_slots.sv */
// Top level of the wear-levelled byte store: controller plus datapath.
// Depends on ewls_pkg, ewls_ctrl and ewls_dp.
//
// An item is taken when start is high and busy is low; its one result shows
// for exactly one cycle with out_strobe high, and the receiver cannot stall.
// After reset the block erases the whole store (busy high), one byte a
// cycle. All work goes through a single memory port with registered read
// data, one access per cycle. A write or update that wraps the ring first
// erases the partition's control bytes. A mount sets up the geometry,
// including a bit-serial division by the partition count, then per
// partition runs a binary search and a scan over the control bytes, and
// first erases the control bytes when the version changed.
module eeprom_wear_level_slots #(
  parameter int STORE_BYTES    = ewls_pkg::STORE_BYTES_DEF,
  parameter int MAX_PARTITIONS = ewls_pkg::MAX_PART_DEF,
  localparam int AW = $clog2(STORE_BYTES)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [ewls_pkg::KIND_W-1:0]  in_kind,
  input  logic [ewls_pkg::SLOT_W-1:0]  in_slot,
  input  logic [ewls_pkg::VAL_W-1:0]   in_value,
  output logic                         out_strobe,
  output logic [ewls_pkg::VAL_W-1:0]   out_read_value,
  output logic [ewls_pkg::ST_W-1:0]    out_status,
  output logic [AW-1:0]                out_store_address,
  output logic                         out_wrapped,
  input  logic                         cfg_we,
  input  logic [ewls_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [ewls_pkg::CFG_DW-1:0]  cfg_data
);
  import ewls_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  ewls_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .stat       (stat),
    .cmd        (cmd),
    .busy       (busy),
    .out_strobe (out_strobe)
  );

  ewls_dp #(
    .STORE_BYTES    (STORE_BYTES),
    .MAX_PARTITIONS (MAX_PARTITIONS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_kind           (in_kind),
    .in_slot           (in_slot),
    .in_value          (in_value),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_read_value    (out_read_value),
    .out_status        (out_status),
    .out_store_address (out_store_address),
    .out_wrapped       (out_wrapped)
  );

endmodule

/* hdl/ewls_dp.sv */
// Datapath of the wear-levelled store: byte memory, geometry, divider,
// search registers and result registers. Depends on ewls_pkg.
module ewls_dp #(
  parameter int STORE_BYTES    = ewls_pkg::STORE_BYTES_DEF,
  parameter int MAX_PARTITIONS = ewls_pkg::MAX_PART_DEF,
  localparam int AW = $clog2(STORE_BYTES)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ewls_pkg::dp_cmd_t            cmd,
  output ewls_pkg::dp_stat_t           stat,
  input  logic [ewls_pkg::KIND_W-1:0]  in_kind,
  input  logic [ewls_pkg::SLOT_W-1:0]  in_slot,
  input  logic [ewls_pkg::VAL_W-1:0]   in_value,
  input  logic                         cfg_we,
  input  logic [ewls_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [ewls_pkg::CFG_DW-1:0]  cfg_data,
  output logic [ewls_pkg::VAL_W-1:0]   out_read_value,
  output logic [ewls_pkg::ST_W-1:0]    out_status,
  output logic [AW-1:0]                out_store_address,
  output logic                         out_wrapped
);
  import ewls_pkg::*;

  localparam int PW  = $clog2(MAX_PARTITIONS + 1);
  localparam int PIW = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
  localparam int DVW = (PW > 4) ? PW : 4;
  localparam int RW  = DVW + 1;
  localparam int DW  = AW + 1;
  localparam int KW  = $clog2(DW + 1);
  localparam int CW  = $clog2((STORE_BYTES + 8) / 9 + 1);
  localparam int LX  = (DW > LEN_W) ? DW : LEN_W;
  localparam int NX  = (PW > CNT_W) ? PW : CNT_W;
  localparam int SX  = (PW > SLOT_W) ? PW : SLOT_W;
  localparam int LW  = AW + 4;
  localparam int MW  = AW + 14;
  // Reciprocal of 9 scaled by 2^16; the quotient is exact for sums below 2^15.
  localparam int RECIP9 = 7282;

  logic [7:0]        mem [STORE_BYTES];
  logic [7:0]        rdata_r;
  logic [AW-1:0]     mem_addr;
  logic              mem_we;
  logic [7:0]        mem_wdata;

  logic [CNT_W-1:0]  cfg_cnt_r;
  logic [LEN_W-1:0]  cfg_len_r;
  logic [VER_W-1:0]  cfg_ver_r;
  logic [PW-1:0]     mounted_r;
  logic [AW-1:0]     clr_r;
  logic [KW-1:0]     div_cnt_r;

  logic [AW-1:0]     psize_r;
  logic [CW-1:0]     cc_r;
  logic [AW-1:0]     last_r [MAX_PARTITIONS];
  logic              has_r  [MAX_PARTITIONS];
  logic [KIND_W-1:0] kind_r;
  logic [SLOT_W-1:0] slot_r;
  logic [VAL_W-1:0]  value_r;
  logic [PIW-1:0]    p_r;
  logic [AW-1:0]     base_r, lo_r, hi_r, mid_r, ci_r, cb_r, pos_r;
  logic [CW-1:0]     ei_r;
  logic [7:0]        cur_r;
  logic              dir_r, mixed_r, ver_diff_r;
  logic [DW-1:0]     div_q_r;
  logic [RW-1:0]     div_rem_r;
  logic [DVW-1:0]    div_d_r;
  logic [VAL_W-1:0]  res_rv_r;
  logic [ST_W-1:0]   res_st_r;
  logic [AW-1:0]     res_addr_r;
  logic              res_wrap_r;

  logic [AW-1:0]     ds, ce, endm1, slot_last, prev, rel, cb_acc, cb_c, mid_c, ci_step;
  logic [AW-1:0]     base_acc;
  logic [AW:0]       endx, pos_w;
  logic [PIW-1:0]    sidx;
  logic              slot_has, need_wrap, is_read;
  logic [PW-1:0]     n_c;
  logic [AW-1:0]     len_c;
  logic [LX-1:0]     len_x;
  logic [NX-1:0]     cnt_x;
  logic [SLOT_W+AW-1:0] prod;
  logic [RW-1:0]     rem_sh;
  logic              rem_ge;
  logic [3:0]        tones;
  logic [LW-1:0]     lastx;
  logic [AW-1:0]     offs;
  logic [AW:0]       cc_num;
  logic [MW-1:0]     cc_prod;

  function automatic logic [3:0] trail_ones(input logic [7:0] b);
    logic [3:0] n;
    logic       run;
    n   = 4'd0;
    run = 1'b1;
    for (int k = 0; k < 8; k++) begin
      if (run && b[k]) n = n + 4'd1;
      else run = 1'b0;
    end
    return n;
  endfunction

  // Geometry of the addressed partition.
  assign ds        = base_r + AW'(cc_r);
  assign ce        = ds - AW'(1);
  assign endx      = {1'b0, base_r} + (AW+1)'(psize_r);
  assign endm1     = AW'(endx - (AW+1)'(1));
  assign sidx      = PIW'(slot_r);
  assign slot_last = last_r[sidx];
  assign slot_has  = has_r[sidx];
  assign prev      = slot_has ? slot_last : ce;
  assign pos_w     = {1'b0, prev} + (AW+1)'(1);
  assign need_wrap = (pos_w >= endx);
  assign rel       = pos_r - ds;
  assign cb_acc    = base_r + (rel >> 3);
  assign is_read   = (kind_r == KIND_READ);
  assign prod      = (SLOT_W+AW)'(slot_r) * (SLOT_W+AW)'(psize_r);
  assign base_acc  = AW'(prod) + AW'(1);

  // Search address helpers.
  assign mid_c   = lo_r + ((hi_r - lo_r) >> 1);
  assign ci_step = dir_r ? ci_r + AW'(1) : ci_r - AW'(1);
  assign cb_c    = (dir_r || mixed_r || ci_r >= ce) ? ci_r : ci_r + AW'(1);

  // Clamped mount configuration.
  assign len_x = LX'(cfg_len_r);
  assign len_c = (len_x > LX'(STORE_BYTES - 1)) ? AW'(STORE_BYTES - 1) : AW'(len_x);
  assign cnt_x = NX'(cfg_cnt_r);
  always_comb begin
    if (cnt_x == NX'(0)) n_c = PW'(1);
    else if (cnt_x > NX'(MAX_PARTITIONS)) n_c = PW'(MAX_PARTITIONS);
    else n_c = PW'(cnt_x);
  end

  assign rem_sh = {div_rem_r[RW-2:0], div_q_r[DW-1]};
  assign rem_ge = (rem_sh >= RW'(div_d_r));

  // Control byte count, ceil(size / 9), by reciprocal multiplication.
  assign cc_num  = (AW+1)'(psize_r) + (AW+1)'(8);
  assign cc_prod = MW'(cc_num) * MW'(RECIP9);

  // Newest position recovered from one control byte.
  assign tones = trail_ones(rdata_r);
  assign offs  = cb_r - base_r;
  assign lastx = LW'(ds) + (LW'(offs) << 3) + LW'(7) - LW'(tones);

  always_comb begin
    stat.clr_last   = (clr_r == AW'(STORE_BYTES - 1));
    stat.mount      = (kind_r == KIND_MOUNT);
    stat.div_done   = (div_cnt_r == KW'(0));
    stat.no_room    = (psize_r <= AW'(cc_r));
    stat.ver_diff   = ver_diff_r;
    stat.erase_last = (ei_r == cc_r - CW'(1));
    stat.lo_gt_hi   = (lo_r > hi_r);
    stat.mixed      = (rdata_r != BYTE_ZERO) && (rdata_r != BYTE_ERASED);
    stat.scan_go    = dir_r ? ((cur_r == BYTE_ZERO) && (ci_r < ce))
                            : ((cur_r == BYTE_ERASED) && (ci_r >= base_r));
    stat.part_last  = (PW'(p_r) + PW'(1) == mounted_r);
    stat.slot_bad   = (SX'(slot_r) >= SX'(mounted_r));
    stat.rd         = is_read;
    stat.has        = slot_has;
    stat.equal      = (kind_r == KIND_UPDATE) && slot_has && (rdata_r == value_r);
    stat.wrap       = need_wrap;
  end

  // Single memory port: one address per cycle, read data registered.
  always_comb begin
    mem_addr  = AW'(0);
    mem_we    = 1'b0;
    mem_wdata = BYTE_ERASED;
    unique case (cmd.op)
      OP_CLR: begin
        mem_addr = clr_r;
        mem_we   = 1'b1;
      end
      OP_M_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = cfg_ver_r;
      end
      OP_ERASE: begin
        mem_addr = base_r + AW'(ei_r);
        mem_we   = 1'b1;
      end
      OP_BS_RD:   mem_addr = mid_c;
      OP_SCAN:    mem_addr = ci_step;
      OP_REC_RD:  mem_addr = cb_c;
      OP_A_RD:    mem_addr = is_read ? slot_last : prev;
      OP_A_WR: begin
        mem_addr  = pos_r;
        mem_we    = 1'b1;
        mem_wdata = value_r;
      end
      OP_A_CB_RD: mem_addr = cb_acc;
      OP_A_CB_WR: begin
        mem_addr  = cb_r;
        mem_we    = 1'b1;
        mem_wdata = rdata_r & ~(8'h80 >> rel[2:0]);
      end
      default: mem_addr = AW'(0);
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    rdata_r <= mem[mem_addr];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_cnt_r <= CNT_W'(1);
      cfg_len_r <= LEN_W'(1023);
      cfg_ver_r <= VER_W'(0);
      mounted_r <= PW'(0);
      clr_r     <= AW'(0);
      div_cnt_r <= KW'(0);
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_COUNT:   cfg_cnt_r <= cfg_data[CNT_W-1:0];
          CFG_LENGTH:  cfg_len_r <= cfg_data[LEN_W-1:0];
          CFG_VERSION: cfg_ver_r <= cfg_data[VER_W-1:0];
          default: ;
        endcase
      end
      if (cmd.op == OP_CLR) clr_r <= clr_r + AW'(1);
      if (cmd.op == OP_M_INIT) mounted_r <= n_c;
      if (cmd.op == OP_M_INIT) div_cnt_r <= KW'(DW);
      else if (cmd.op == OP_DIV) div_cnt_r <= div_cnt_r - KW'(1);
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        kind_r     <= in_kind;
        slot_r     <= in_slot;
        value_r    <= in_value;
        res_rv_r   <= VAL_W'(0);
        res_st_r   <= ST_OK;
        res_addr_r <= AW'(0);
        res_wrap_r <= 1'b0;
      end
      OP_A_CHK: begin
        base_r <= base_acc;
        if (stat.slot_bad) res_st_r <= ST_SLOT;
        else if (is_read && !slot_has) res_st_r <= ST_EMPTY;
        else if (!is_read && stat.no_room) res_st_r <= ST_EMPTY;
      end
      OP_A_RVAL: begin
        res_rv_r   <= rdata_r;
        res_addr_r <= slot_last;
      end
      OP_A_CMP: begin
        ei_r <= CW'(0);
        if (stat.equal) begin
          res_st_r <= ST_EQUAL;
        end else begin
          pos_r      <= need_wrap ? ds : AW'(pos_w);
          res_wrap_r <= need_wrap;
        end
      end
      OP_ERASE: ei_r <= ei_r + CW'(1);
      OP_A_CB_RD: cb_r <= cb_acc;
      OP_A_CB_WR: begin
        last_r[sidx] <= pos_r;
        has_r[sidx]  <= 1'b1;
        res_addr_r   <= pos_r;
      end
      OP_M_INIT: begin
        ver_diff_r <= (rdata_r != cfg_ver_r);
        for (int i = 0; i < MAX_PARTITIONS; i++) begin
          has_r[i]  <= 1'b0;
          last_r[i] <= AW'(0);
        end
        div_q_r   <= DW'(len_c);
        div_rem_r <= RW'(0);
        div_d_r   <= DVW'(n_c);
      end
      OP_DIV: begin
        div_q_r   <= {div_q_r[DW-2:0], rem_ge};
        div_rem_r <= rem_ge ? rem_sh - RW'(div_d_r) : rem_sh;
      end
      OP_M_CC: psize_r <= AW'(div_q_r);
      OP_M_GEOM: begin
        cc_r   <= CW'(cc_prod >> 16);
        p_r    <= PIW'(0);
        base_r <= AW'(1);
      end
      OP_PART: ei_r <= CW'(0);
      OP_BS_INIT: begin
        lo_r <= base_r;
        hi_r <= ce;
      end
      OP_BS_RD: mid_r <= mid_c;
      OP_BS_EV: begin
        cur_r   <= rdata_r;
        ci_r    <= mid_r;
        dir_r   <= (rdata_r == BYTE_ZERO);
        mixed_r <= stat.mixed;
        if (rdata_r == BYTE_ZERO) lo_r <= mid_r + AW'(1);
        else if (rdata_r == BYTE_ERASED) hi_r <= mid_r - AW'(1);
      end
      OP_SCAN: ci_r <= ci_step;
      OP_SCAN_EV: cur_r <= rdata_r;
      OP_REC_RD: cb_r <= cb_c;
      OP_REC: begin
        // An all-erased first control byte means the partition holds nothing.
        if (!(cb_r == base_r && rdata_r == BYTE_ERASED)) begin
          has_r[p_r]  <= 1'b1;
          last_r[p_r] <= (lastx > LW'(endm1)) ? endm1 : AW'(lastx);
        end
        p_r    <= p_r + PIW'(1);
        base_r <= base_r + psize_r;
      end
      default: ;
    endcase
  end

  assign out_read_value    = res_rv_r;
  assign out_status        = res_st_r;
  assign out_store_address = res_addr_r;
  assign out_wrapped       = res_wrap_r;

endmodule

/* hdl/ewls_ctrl.sv */
// Controller state machine of the wear-levelled store: sequences the
// datapath through clearing, accesses and mount. Depends on ewls_pkg.
`include "assert_macros.svh"
module ewls_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  ewls_pkg::dp_stat_t stat,
  output ewls_pkg::dp_cmd_t  cmd,
  output logic               busy,
  output logic               out_strobe
);
  import ewls_pkg::*;

  localparam logic [4:0] S_CLEAR   = 5'd0;
  localparam logic [4:0] S_IDLE    = 5'd1;
  localparam logic [4:0] S_ACC     = 5'd2;
  localparam logic [4:0] S_A_RD    = 5'd3;
  localparam logic [4:0] S_A_RVAL  = 5'd4;
  localparam logic [4:0] S_A_CMP   = 5'd5;
  localparam logic [4:0] S_ERASE   = 5'd6;
  localparam logic [4:0] S_A_WR    = 5'd7;
  localparam logic [4:0] S_A_CB_RD = 5'd8;
  localparam logic [4:0] S_A_CB_WR = 5'd9;
  localparam logic [4:0] S_M_VER   = 5'd10;
  localparam logic [4:0] S_M_INIT  = 5'd11;
  localparam logic [4:0] S_M_DIV1  = 5'd12;
  localparam logic [4:0] S_M_CC    = 5'd13;
  localparam logic [4:0] S_M_GEOM  = 5'd15;
  localparam logic [4:0] S_M_CHK   = 5'd16;
  localparam logic [4:0] S_M_PART  = 5'd17;
  localparam logic [4:0] S_BS_INIT = 5'd18;
  localparam logic [4:0] S_BS_RD   = 5'd19;
  localparam logic [4:0] S_BS_EV   = 5'd20;
  localparam logic [4:0] S_SCAN    = 5'd21;
  localparam logic [4:0] S_SCAN_EV = 5'd22;
  localparam logic [4:0] S_REC_RD  = 5'd23;
  localparam logic [4:0] S_REC     = 5'd24;
  localparam logic [4:0] S_DONE    = 5'd25;

  logic [4:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLEAR;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NOP;
    unique case (state_r)
      S_CLEAR: begin
        cmd.op = OP_CLR;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        if (stat.mount) begin
          state_nxt = S_M_VER;
        end else begin
          cmd.op = OP_A_CHK;
          if (stat.slot_bad) state_nxt = S_DONE;
          else if (stat.rd) state_nxt = stat.has ? S_A_RD : S_DONE;
          else state_nxt = stat.no_room ? S_DONE : S_A_RD;
        end
      end
      S_A_RD: begin
        cmd.op    = OP_A_RD;
        state_nxt = stat.rd ? S_A_RVAL : S_A_CMP;
      end
      S_A_RVAL: begin
        cmd.op    = OP_A_RVAL;
        state_nxt = S_DONE;
      end
      S_A_CMP: begin
        cmd.op = OP_A_CMP;
        if (stat.equal) state_nxt = S_DONE;
        else if (stat.wrap) state_nxt = S_ERASE;
        else state_nxt = S_A_WR;
      end
      S_ERASE: begin
        cmd.op = OP_ERASE;
        if (stat.erase_last) state_nxt = stat.mount ? S_BS_INIT : S_A_WR;
      end
      S_A_WR: begin
        cmd.op    = OP_A_WR;
        state_nxt = S_A_CB_RD;
      end
      S_A_CB_RD: begin
        cmd.op    = OP_A_CB_RD;
        state_nxt = S_A_CB_WR;
      end
      S_A_CB_WR: begin
        cmd.op    = OP_A_CB_WR;
        state_nxt = S_DONE;
      end
      S_M_VER: begin
        cmd.op    = OP_M_VER;
        state_nxt = S_M_INIT;
      end
      S_M_INIT: begin
        cmd.op    = OP_M_INIT;
        state_nxt = S_M_DIV1;
      end
      S_M_DIV1: begin
        if (stat.div_done) state_nxt = S_M_CC;
        else cmd.op = OP_DIV;
      end
      S_M_CC: begin
        cmd.op    = OP_M_CC;
        state_nxt = S_M_GEOM;
      end
      S_M_GEOM: begin
        cmd.op    = OP_M_GEOM;
        state_nxt = S_M_CHK;
      end
      S_M_CHK: begin
        state_nxt = stat.no_room ? S_DONE : S_M_PART;
      end
      S_M_PART: begin
        cmd.op    = OP_PART;
        state_nxt = stat.ver_diff ? S_ERASE : S_BS_INIT;
      end
      S_BS_INIT: begin
        cmd.op    = OP_BS_INIT;
        state_nxt = S_BS_RD;
      end
      S_BS_RD: begin
        if (stat.lo_gt_hi) begin
          state_nxt = S_SCAN;
        end else begin
          cmd.op    = OP_BS_RD;
          state_nxt = S_BS_EV;
        end
      end
      S_BS_EV: begin
        cmd.op    = OP_BS_EV;
        state_nxt = stat.mixed ? S_REC_RD : S_BS_RD;
      end
      S_SCAN: begin
        // Walk past runs of full or erased control bytes after the search.
        if (stat.scan_go) begin
          cmd.op    = OP_SCAN;
          state_nxt = S_SCAN_EV;
        end else begin
          state_nxt = S_REC_RD;
        end
      end
      S_SCAN_EV: begin
        cmd.op    = OP_SCAN_EV;
        state_nxt = S_SCAN;
      end
      S_REC_RD: begin
        cmd.op    = OP_REC_RD;
        state_nxt = S_REC;
      end
      S_REC: begin
        cmd.op    = OP_REC;
        state_nxt = stat.part_last ? S_DONE : S_M_PART;
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = (state_r == S_DONE);

  `AST_NEXT(a_strobe_single, out_strobe, !out_strobe)
  `AST_NEXT(a_accept_busy, start && !busy, busy)
  `AST_NEXT(a_done_idle, out_strobe, !busy)

endmodule
